[hdl/pfv_pkg.sv]
// Shared types, codes and defaults for the parent forest validator.
package pfv_pkg;

  localparam int unsigned MaxNodesDef     = 8192;
  localparam int unsigned MaxNameBytesDef = 160;
  localparam int unsigned CountW          = 14;

  localparam logic [1:0] COL_WHITE = 2'd0;
  localparam logic [1:0] COL_GRAY  = 2'd1;
  localparam logic [1:0] COL_BLACK = 2'd2;

  typedef enum logic [2:0] {
    CAUSE_OK       = 3'd0,
    CAUSE_NAME     = 3'd1,
    CAUSE_TOO_MANY = 3'd2,
    CAUSE_BAD_NODE = 3'd3,
    CAUSE_DUP      = 3'd4,
    CAUSE_MISSING  = 3'd5,
    CAUSE_CYCLE    = 3'd6
  } cause_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CHECK,
    ST_DSRD,
    ST_DSCMP,
    ST_END,
    ST_CLR,
    ST_WSTART,
    ST_P1RD,
    ST_P1EV,
    ST_P1SRD,
    ST_P1SCMP,
    ST_P2RD,
    ST_P2EV,
    ST_P2SRD,
    ST_P2SCMP,
    ST_DONE
  } state_e;

  typedef struct packed {
    logic       load_rec;
    logic       key_in;
    logic       key_par;
    logic       idx_clr;
    logic       idx_inc;
    logic       rd_id;
    logic       rd_node;
    logic       col_we;
    logic       col_at_idx;
    logic [1:0] col_val;
    logic       store;
    logic       cnt_inc;
    logic       set_fault;
    logic       set_ovf;
    logic       cur_i;
    logic       cur_idx;
    logic       i_clr;
    logic       i_inc;
    logic       set_cause;
    cause_e     cause;
    logic       out_load;
  } cmd_t;

  typedef struct packed {
    logic       carries;
    logic       last;
    logic       good;
    logic       cnt_full;
    cause_e     fault;
    logic       ovf;
    logic       scene_ok;
    logic       idx_end;
    logic       id_match;
    logic [1:0] col;
    logic       par_zero;
    logic       i_end;
    logic       out_busy;
  } sts_t;

endpackage

[hdl/parent_forest_validator_core.sv]
// Top level of the parent forest validator: sequencer plus datapath.
//
//  channel  dir  handshake                      payload
//  cfg      in   cfg_we_i                       cfg_scene_name_bytes_i
//  in       in   in_valid_i / in_ready_o        carries_node_i .. last_i
//  out      out  out_valid_o / out_ready_i      set_ok_o, fail_cause_o, node_count_o
//
// One beat at a time: in_ready_o is high only in IDLE. Every beat passes CHECK and
// END; a record that passes its checks first scans the stored ids for a duplicate.
// A last beat then goes to DONE; a clean set first clears the colours of all stored
// nodes and walks each node's parent chain in two passes, scanning ids for each parent.
// Async active-low reset clears control state; memories hold no reset.
// A verdict waits in the output register; DONE stalls only while it is unread.
module parent_forest_validator_core import pfv_pkg::*; #(
  parameter int unsigned MAX_NODES      = MaxNodesDef,
  parameter int unsigned MAX_NAME_BYTES = MaxNameBytesDef
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic [7:0]        cfg_scene_name_bytes_i,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic              carries_node_i,
  input  logic [63:0]       node_id_i,
  input  logic [63:0]       parent_id_i,
  input  logic              is_group_i,
  input  logic [31:0]       tag_i,
  input  logic [7:0]        object_type_i,
  input  logic [7:0]        name_bytes_i,
  input  logic              transform_finite_i,
  input  logic              scale_positive_i,
  input  logic              last_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic              set_ok_o,
  output logic [2:0]        fail_cause_o,
  output logic [CountW-1:0] node_count_o
);

  cmd_t cmd;
  sts_t sts;

  pfv_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  pfv_datapath #(
    .MAX_NODES      (MAX_NODES),
    .MAX_NAME_BYTES (MAX_NAME_BYTES)
  ) u_dp (
    .clk_i                  (clk_i),
    .rst_ni                 (rst_ni),
    .cfg_we_i               (cfg_we_i),
    .cfg_scene_name_bytes_i (cfg_scene_name_bytes_i),
    .carries_node_i         (carries_node_i),
    .node_id_i              (node_id_i),
    .parent_id_i            (parent_id_i),
    .is_group_i             (is_group_i),
    .tag_i                  (tag_i),
    .object_type_i          (object_type_i),
    .name_bytes_i           (name_bytes_i),
    .transform_finite_i     (transform_finite_i),
    .scale_positive_i       (scale_positive_i),
    .last_i                 (last_i),
    .cmd_i                  (cmd),
    .sts_o                  (sts),
    .out_valid_o            (out_valid_o),
    .out_ready_i            (out_ready_i),
    .set_ok_o               (set_ok_o),
    .fail_cause_o           (fail_cause_o),
    .node_count_o           (node_count_o)
  );

  // verdict flag agrees with its cause
  a_ok_matches_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (set_ok_o == (fail_cause_o == CAUSE_OK)))
    else $error("set_ok disagrees with fail_cause");

  // records are only written into a clean, non-full set
  a_store_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.store |-> (sts.fault == CAUSE_OK && !sts.cnt_full))
    else $error("record stored after a fault or past capacity");

  // one beat in flight: no second beat the cycle after one is taken
  a_one_beat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> !in_ready_o)
    else $error("beat accepted while previous beat still in work");

endmodule

[hdl/pfv_datapath.sv]
// Record latch, id/parent/colour memories, counters and result register.
module pfv_datapath import pfv_pkg::*; #(
  parameter int unsigned MAX_NODES      = MaxNodesDef,
  parameter int unsigned MAX_NAME_BYTES = MaxNameBytesDef
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic [7:0]        cfg_scene_name_bytes_i,
  input  logic              carries_node_i,
  input  logic [63:0]       node_id_i,
  input  logic [63:0]       parent_id_i,
  input  logic              is_group_i,
  input  logic [31:0]       tag_i,
  input  logic [7:0]        object_type_i,
  input  logic [7:0]        name_bytes_i,
  input  logic              transform_finite_i,
  input  logic              scale_positive_i,
  input  logic              last_i,
  input  cmd_t              cmd_i,
  output sts_t              sts_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic              set_ok_o,
  output logic [2:0]        fail_cause_o,
  output logic [CountW-1:0] node_count_o
);

  localparam int unsigned AW = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1;
  localparam int unsigned CW = $clog2(MAX_NODES + 1);

  logic [63:0]   id_mem  [MAX_NODES];
  logic [63:0]   par_mem [MAX_NODES];
  logic [1:0]    col_mem [MAX_NODES];

  logic [7:0]    cfg_q;
  logic [CW-1:0] cnt_q, idx_q, i_q;
  logic [AW-1:0] cur_q, col_addr;
  cause_e        fault_q, cause_q;
  logic          ovf_q;
  logic          rec_carries_q, rec_last_q, rec_good_q;
  logic [63:0]   rec_id_q, rec_par_q, key_q;
  logic [63:0]   id_rd_q, par_rd_q;
  logic [1:0]    col_rd_q;
  logic          out_valid_q, set_ok_q;
  logic [2:0]    fail_cause_q;
  logic [CountW-1:0] node_count_q;
  logic          good;

  always_comb begin
    good = (node_id_i != 64'd0) && (parent_id_i != node_id_i)
        && (is_group_i ? (tag_i == 32'd0 && object_type_i == 8'd0) : (tag_i != 32'd0))
        && (name_bytes_i <= 8'(MAX_NAME_BYTES))
        && transform_finite_i && scale_positive_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q         <= 8'd0;
      cnt_q         <= '0;
      idx_q         <= '0;
      i_q           <= '0;
      fault_q       <= CAUSE_OK;
      ovf_q         <= 1'b0;
      rec_carries_q <= 1'b0;
      rec_last_q    <= 1'b0;
      out_valid_q   <= 1'b0;
    end else begin
      if (cfg_we_i) cfg_q <= cfg_scene_name_bytes_i;
      if (cmd_i.load_rec) begin
        rec_carries_q <= carries_node_i;
        rec_last_q    <= last_i;
      end
      if (cmd_i.idx_clr) idx_q <= '0;
      else if (cmd_i.idx_inc) idx_q <= idx_q + CW'(1);
      if (cmd_i.i_clr) i_q <= '0;
      else if (cmd_i.i_inc) i_q <= i_q + CW'(1);
      if (cmd_i.set_fault) fault_q <= cmd_i.cause;
      if (cmd_i.set_ovf) ovf_q <= 1'b1;
      if (cmd_i.cnt_inc) cnt_q <= cnt_q + CW'(1);
      if (cmd_i.out_load) begin
        // verdict leaves; the set state clears for the next set
        out_valid_q <= 1'b1;
        cnt_q       <= '0;
        fault_q     <= CAUSE_OK;
        ovf_q       <= 1'b0;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_rec) begin
      rec_id_q   <= node_id_i;
      rec_par_q  <= parent_id_i;
      rec_good_q <= good;
    end
    if (cmd_i.key_in) key_q <= rec_id_q;
    else if (cmd_i.key_par) key_q <= par_rd_q;
    if (cmd_i.cur_i) cur_q <= i_q[AW-1:0];
    else if (cmd_i.cur_idx) cur_q <= idx_q[AW-1:0];
    if (cmd_i.set_cause) cause_q <= cmd_i.cause;
    if (cmd_i.out_load) begin
      set_ok_q     <= (cause_q == CAUSE_OK);
      fail_cause_q <= cause_q;
      node_count_q <= CountW'(cnt_q);
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.store) begin
      id_mem[cnt_q[AW-1:0]]  <= rec_id_q;
      par_mem[cnt_q[AW-1:0]] <= rec_par_q;
    end
    if (cmd_i.rd_id) id_rd_q <= id_mem[idx_q[AW-1:0]];
    if (cmd_i.rd_node) par_rd_q <= par_mem[cur_q];
  end

  assign col_addr = cmd_i.col_at_idx ? idx_q[AW-1:0] : cur_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.col_we) col_mem[col_addr] <= cmd_i.col_val;
    if (cmd_i.rd_node) col_rd_q <= col_mem[cur_q];
  end

  always_comb begin
    sts_o.carries  = rec_carries_q;
    sts_o.last     = rec_last_q;
    sts_o.good     = rec_good_q;
    sts_o.cnt_full = (cnt_q == CW'(MAX_NODES));
    sts_o.fault    = fault_q;
    sts_o.ovf      = ovf_q;
    sts_o.scene_ok = (cfg_q != 8'd0) && (cfg_q <= 8'(MAX_NAME_BYTES));
    sts_o.idx_end  = (idx_q == cnt_q);
    sts_o.id_match = (id_rd_q == key_q);
    sts_o.col      = col_rd_q;
    sts_o.par_zero = (par_rd_q == 64'd0);
    sts_o.i_end    = (i_q == cnt_q);
    sts_o.out_busy = out_valid_q && !out_ready_i;
  end

  assign out_valid_o  = out_valid_q;
  assign set_ok_o     = set_ok_q;
  assign fail_cause_o = fail_cause_q;
  assign node_count_o = node_count_q;

endmodule

[hdl/pfv_ctrl.sv]
// Sequencer: load checks, duplicate search, colour clear and the two-pass chain walk.
module pfv_ctrl import pfv_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_ready_o,
  input  sts_t sts_i,
  output cmd_t cmd_o
);

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= ST_IDLE;
    else         state_q <= state_d;
  end

  assign in_ready_o = (state_q == ST_IDLE);

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE:   if (in_valid_i) state_d = ST_CHECK;
      ST_CHECK: begin
        if (sts_i.carries && !sts_i.cnt_full && sts_i.fault == CAUSE_OK && sts_i.good)
          state_d = ST_DSRD;
        else
          state_d = ST_END;
      end
      ST_DSRD:   state_d = sts_i.idx_end ? ST_END : ST_DSCMP;
      ST_DSCMP:  state_d = sts_i.id_match ? ST_END : ST_DSRD;
      ST_END: begin
        if (!sts_i.last) state_d = ST_IDLE;
        else if (!sts_i.scene_ok || sts_i.ovf || sts_i.fault != CAUSE_OK) state_d = ST_DONE;
        else state_d = ST_CLR;
      end
      ST_CLR:    if (sts_i.idx_end) state_d = ST_WSTART;
      ST_WSTART: state_d = sts_i.i_end ? ST_DONE : ST_P1RD;
      ST_P1RD:   state_d = ST_P1EV;
      ST_P1EV: begin
        if (sts_i.col == COL_GRAY) state_d = ST_DONE;
        else if (sts_i.col == COL_BLACK || sts_i.par_zero) state_d = ST_P2RD;
        else state_d = ST_P1SRD;
      end
      ST_P1SRD:  state_d = sts_i.idx_end ? ST_DONE : ST_P1SCMP;
      ST_P1SCMP: state_d = sts_i.id_match ? ST_P1RD : ST_P1SRD;
      ST_P2RD:   state_d = ST_P2EV;
      ST_P2EV: begin
        if (sts_i.col == COL_BLACK || sts_i.par_zero) state_d = ST_WSTART;
        else state_d = ST_P2SRD;
      end
      ST_P2SRD:  state_d = sts_i.idx_end ? ST_WSTART : ST_P2SCMP;
      ST_P2SCMP: state_d = sts_i.id_match ? ST_P2RD : ST_P2SRD;
      ST_DONE:   if (!sts_i.out_busy) state_d = ST_IDLE;
      default:   state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o = '0;
    case (state_q)
      ST_IDLE: cmd_o.load_rec = in_valid_i;
      ST_CHECK: begin
        if (sts_i.carries) begin
          if (sts_i.cnt_full) begin
            cmd_o.set_ovf = 1'b1;
          end else if (sts_i.fault != CAUSE_OK) begin
            cmd_o.cnt_inc = 1'b1;
          end else if (!sts_i.good) begin
            cmd_o.set_fault = 1'b1;
            cmd_o.cause     = CAUSE_BAD_NODE;
            cmd_o.cnt_inc   = 1'b1;
          end else begin
            cmd_o.key_in  = 1'b1;
            cmd_o.idx_clr = 1'b1;
          end
        end
      end
      ST_DSRD: begin
        if (sts_i.idx_end) begin
          cmd_o.store   = 1'b1;
          cmd_o.cnt_inc = 1'b1;
        end else begin
          cmd_o.rd_id = 1'b1;
        end
      end
      ST_DSCMP: begin
        if (sts_i.id_match) begin
          cmd_o.set_fault = 1'b1;
          cmd_o.cause     = CAUSE_DUP;
          cmd_o.cnt_inc   = 1'b1;
        end else begin
          cmd_o.idx_inc = 1'b1;
        end
      end
      ST_END: begin
        cmd_o.set_cause = 1'b1;
        if (!sts_i.scene_ok) cmd_o.cause = CAUSE_NAME;
        else if (sts_i.ovf) cmd_o.cause = CAUSE_TOO_MANY;
        else cmd_o.cause = sts_i.fault;
        cmd_o.idx_clr = 1'b1;
      end
      ST_CLR: begin
        if (sts_i.idx_end) begin
          cmd_o.i_clr = 1'b1;
        end else begin
          cmd_o.col_we     = 1'b1;
          cmd_o.col_at_idx = 1'b1;
          cmd_o.col_val    = COL_WHITE;
          cmd_o.idx_inc    = 1'b1;
        end
      end
      ST_WSTART: begin
        if (sts_i.i_end) begin
          cmd_o.set_cause = 1'b1;
          cmd_o.cause     = CAUSE_OK;
        end else begin
          cmd_o.cur_i = 1'b1;
        end
      end
      ST_P1RD, ST_P2RD: cmd_o.rd_node = 1'b1;
      ST_P1EV: begin
        if (sts_i.col == COL_GRAY) begin
          cmd_o.set_cause = 1'b1;
          cmd_o.cause     = CAUSE_CYCLE;
        end else if (sts_i.col == COL_BLACK) begin
          cmd_o.cur_i = 1'b1;
        end else begin
          cmd_o.col_we  = 1'b1;
          cmd_o.col_val = COL_GRAY;
          if (sts_i.par_zero) begin
            cmd_o.cur_i = 1'b1;
          end else begin
            cmd_o.key_par = 1'b1;
            cmd_o.idx_clr = 1'b1;
          end
        end
      end
      ST_P1SRD: begin
        if (sts_i.idx_end) begin
          cmd_o.set_cause = 1'b1;
          cmd_o.cause     = CAUSE_MISSING;
        end else begin
          cmd_o.rd_id = 1'b1;
        end
      end
      ST_P1SCMP, ST_P2SCMP: begin
        if (sts_i.id_match) cmd_o.cur_idx = 1'b1;
        else cmd_o.idx_inc = 1'b1;
      end
      ST_P2EV: begin
        if (sts_i.col == COL_BLACK) begin
          cmd_o.i_inc = 1'b1;
        end else begin
          cmd_o.col_we  = 1'b1;
          cmd_o.col_val = COL_BLACK;
          if (sts_i.par_zero) begin
            cmd_o.i_inc = 1'b1;
          end else begin
            cmd_o.key_par = 1'b1;
            cmd_o.idx_clr = 1'b1;
          end
        end
      end
      ST_P2SRD: begin
        if (sts_i.idx_end) cmd_o.i_inc = 1'b1;
        else cmd_o.rd_id = 1'b1;
      end
      ST_DONE: cmd_o.out_load = !sts_i.out_busy;
      default: cmd_o = '0;
    endcase
  end

endmodule

[test/parent_forest_validator_core_tb.sv]
// Testbench for parent_forest_validator_core: random record sets checked against a forest predictor.
`timescale 1ns / 1ps

module parent_forest_validator_core_tb import pfv_pkg::*; ();

  typedef struct {
    bit        carries;
    bit [63:0] id;
    bit [63:0] par;
    bit        grp;
    bit [31:0] tag;
    bit [7:0]  typ;
    bit [7:0]  nb;
    bit        fin;
    bit        pos;
    bit        last;
  } record_t;

  typedef struct {
    bit          ok;
    cause_e      cause;
    bit [13:0]   count;
  } verdict_t;

  // Tracks the set being loaded and queues the verdict each last beat should give.
  class verdict_board;
    bit [7:0]    scene;
    bit [63:0]   ids[$];
    bit [63:0]   pars[$];
    int unsigned count;
    cause_e      fault;
    bit          ovf;
    verdict_t    pending[$];
    int          errors;
    int          verdicts;

    function new();
      scene = 0;
      clear_set();
    endfunction

    function void clear_set();
      ids.delete();
      pars.delete();
      count = 0;
      fault = CAUSE_OK;
      ovf   = 0;
    endfunction

    function int unsigned locate(bit [63:0] key);
      for (int i = 0; i < ids.size(); i++)
        if (ids[i] == key) return i;
      return ids.size();
    endfunction

    function cause_e walk_forest();
      int unsigned n;
      int unsigned cur;
      bit [1:0] col[];
      n = ids.size();
      col = new[n];
      foreach (col[k]) col[k] = COL_WHITE;
      for (int i = 0; i < n; i++) begin
        cur = i;
        forever begin
          if (col[cur] == COL_GRAY) return CAUSE_CYCLE;
          if (col[cur] == COL_BLACK) break;
          col[cur] = COL_GRAY;
          if (pars[cur] == 0) break;
          cur = locate(pars[cur]);
          if (cur >= n) return CAUSE_MISSING;
        end
        cur = i;
        forever begin
          if (col[cur] == COL_BLACK) break;
          col[cur] = COL_BLACK;
          if (pars[cur] == 0) break;
          cur = locate(pars[cur]);
          if (cur >= n) break;
        end
      end
      return CAUSE_OK;
    endfunction

    function void note_beat(record_t r);
      bit good;
      verdict_t v;
      if (r.carries) begin
        if (count >= MaxNodesDef) ovf = 1;
        else begin
          good = r.id != 0 && r.par != r.id
              && (r.grp ? (r.tag == 0 && r.typ == 0) : r.tag != 0)
              && r.nb <= MaxNameBytesDef && r.fin && r.pos;
          if (fault == CAUSE_OK) begin
            if (!good) fault = CAUSE_BAD_NODE;
            else if (locate(r.id) < ids.size()) fault = CAUSE_DUP;
          end
          if (fault == CAUSE_OK) begin
            ids  = {ids, r.id};
            pars = {pars, r.par};
          end
          count++;
        end
      end
      if (!r.last) return;
      if (scene == 0 || scene > MaxNameBytesDef) v.cause = CAUSE_NAME;
      else if (ovf) v.cause = CAUSE_TOO_MANY;
      else if (fault != CAUSE_OK) v.cause = fault;
      else v.cause = walk_forest();
      v.ok    = v.cause == CAUSE_OK;
      v.count = count[13:0];
      pending = {pending, v};
      clear_set();
    endfunction

    function void check_verdict(bit ok, bit [2:0] cause, bit [13:0] cnt);
      verdict_t v;
      if (pending.size() == 0) begin
        $error("verdict with none expected: set_ok=%0d fail_cause=%0d node_count=%0d",
               ok, cause, cnt);
        errors++;
        return;
      end
      v = pending.pop_front();
      verdicts++;
      if (ok != v.ok) begin
        $error("set_ok: expected %0d, got %0d", v.ok, ok);
        errors++;
      end
      if (cause != v.cause) begin
        $error("fail_cause: expected %0d, got %0d", v.cause, cause);
        errors++;
      end
      if (cnt != v.count) begin
        $error("node_count: expected %0d, got %0d", v.count, cnt);
        errors++;
      end
    endfunction
  endclass

  logic              clk_i = 0;
  logic              rst_ni = 0;
  logic              cfg_we_i = 0;
  logic [7:0]        cfg_scene_name_bytes_i = '0;
  logic              in_valid_i = 0;
  logic              in_ready_o;
  logic              carries_node_i = 0;
  logic [63:0]       node_id_i = '0;
  logic [63:0]       parent_id_i = '0;
  logic              is_group_i = 0;
  logic [31:0]       tag_i = '0;
  logic [7:0]        object_type_i = '0;
  logic [7:0]        name_bytes_i = '0;
  logic              transform_finite_i = 0;
  logic              scale_positive_i = 0;
  logic              last_i = 0;
  logic              out_valid_o;
  logic              out_ready_i = 0;
  logic              set_ok_o;
  logic [2:0]        fail_cause_o;
  logic [CountW-1:0] node_count_o;

  parent_forest_validator_core dut (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_scene_name_bytes_i,
    .in_valid_i, .in_ready_o, .carries_node_i, .node_id_i, .parent_id_i,
    .is_group_i, .tag_i, .object_type_i, .name_bytes_i, .transform_finite_i,
    .scale_positive_i, .last_i, .out_valid_o, .out_ready_i, .set_ok_o,
    .fail_cause_o, .node_count_o
  );

  verdict_board board = new();
  int gap_pct   = 0;
  int stall_pct = 0;
  int records_sent = 0;
  int sets_sent    = 0;

  initial begin
    forever #2 clk_i = ~clk_i;
  end

  initial begin
    #2_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  always @(negedge clk_i) out_ready_i <= $urandom_range(99) >= stall_pct;

  always @(posedge clk_i)
    if (rst_ni && out_valid_o && out_ready_i)
      board.check_verdict(set_ok_o, fail_cause_o, node_count_o);

  function automatic bit [63:0] rand_id();
    bit [63:0] v;
    do v = {$urandom, $urandom}; while (v == 0);
    return v;
  endfunction

  function automatic record_t good_record(bit [63:0] id, bit [63:0] par);
    record_t r;
    r.carries = 1;
    r.id  = id;
    r.par = par;
    r.grp = $urandom_range(3) == 0;
    r.tag = r.grp ? 32'd0 : ($urandom | (32'd1 << $urandom_range(31)));
    r.typ = r.grp ? 8'd0 : 8'($urandom);
    r.nb  = 8'($urandom_range(MaxNameBytesDef));
    r.fin = 1;
    r.pos = 1;
    r.last = 0;
    return r;
  endfunction

  task automatic send_beat(record_t r);
    while ($urandom_range(99) < gap_pct) begin
      in_valid_i = 0;
      @(negedge clk_i);
    end
    in_valid_i         = 1;
    carries_node_i     = r.carries;
    node_id_i          = r.id;
    parent_id_i        = r.par;
    is_group_i         = r.grp;
    tag_i              = r.tag;
    object_type_i      = r.typ;
    name_bytes_i       = r.nb;
    transform_finite_i = r.fin;
    scale_positive_i   = r.pos;
    last_i             = r.last;
    do @(posedge clk_i); while (!in_ready_o);
    board.note_beat(r);
    if (r.carries) records_sent++;
    if (r.last) sets_sent++;
    @(negedge clk_i);
  endtask

  task automatic end_set();
    record_t r;
    r = good_record(rand_id(), rand_id());
    r.carries = 0;
    r.last = 1;
    send_beat(r);
  endtask

  // Register writes only once the block has drained its last verdict.
  task automatic write_scene(bit [7:0] v);
    in_valid_i = 0;
    while (board.pending.size() != 0) @(negedge clk_i);
    repeat (40) @(negedge clk_i);
    cfg_we_i = 1;
    cfg_scene_name_bytes_i = v;
    board.scene = v;
    @(negedge clk_i);
    cfg_we_i = 0;
  endtask

  task automatic send_one(record_t r);
    r.last = 1;
    send_beat(r);
  endtask

  // Random set: mostly a well-formed forest, sometimes with one injected fault.
  task automatic random_set(int n);
    record_t rs[$];
    bit [63:0] ids[];
    bit rev;
    int kind, a, b;
    record_t noise;
    ids = new[n];
    foreach (ids[k]) ids[k] = rand_id();
    rev = 1'($urandom_range(1));
    for (int k = 0; k < n; k++) begin
      bit [63:0] par;
      par = 0;
      if ($urandom_range(9) < 7) begin
        if (!rev && k > 0) par = ids[$urandom_range(k - 1)];
        if (rev && k < n - 1) par = ids[$urandom_range(n - 1, k + 1)];
      end
      rs = {rs, good_record(ids[k], par)};
    end
    kind = $urandom_range(9);
    a = $urandom_range(n - 1);
    b = $urandom_range(n - 1);
    case (kind)
      5: begin
        case ($urandom_range(6))
          0: rs[a].id = 0;
          1: rs[a].par = rs[a].id;
          2: rs[a].nb = 8'($urandom_range(255, MaxNameBytesDef + 1));
          3: rs[a].fin = 0;
          4: rs[a].pos = 0;
          5: rs[a].tag = rs[a].grp ? 32'd1 << $urandom_range(31) : 32'd0;
          default: begin
            rs[a].grp = 1;
            rs[a].tag = 0;
            rs[a].typ = 8'd1 << $urandom_range(7);
          end
        endcase
      end
      6: if (a != b) rs[b].id = rs[a].id;
      7: rs[a].par = rand_id();
      8: if (a != b) begin
        rs[a].par = rs[b].id;
        rs[b].par = rs[a].id;
      end
      default: ;
    endcase
    for (int k = 0; k < n; k++) begin
      if ($urandom_range(19) == 0) begin
        noise = good_record(rand_id(), rand_id());
        noise.carries = 0;
        send_beat(noise);
      end
      rs[k].last = k == n - 1;
      send_beat(rs[k]);
    end
  endtask

  initial begin
    record_t r;
    bit [63:0] x, y;
    int phase;
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1;
    @(negedge clk_i);

    // directed: scene name still zero from reset
    end_set();
    write_scene(1);
    end_set();
    r = good_record('1, 0);
    r.grp = 1; r.tag = 0; r.typ = 0; r.nb = 8'(MaxNameBytesDef);
    send_one(r);
    r = good_record('1, 0);
    r.grp = 0; r.tag = '1; r.typ = '1; r.nb = 0;
    send_one(r);
    r = good_record(1, 0); r.nb = 8'(MaxNameBytesDef + 1); send_one(r);
    r = good_record(1, 0); r.grp = 0; r.tag = 0; send_one(r);
    r = good_record(1, 0); r.grp = 1; r.tag = 0; r.typ = 8'h80; send_one(r);
    r = good_record(1, 0); r.fin = 0; send_one(r);
    r = good_record(1, 0); r.pos = 0; send_one(r);
    r = good_record(0, 0); send_one(r);
    r = good_record(5, 5); send_one(r);
    r = good_record(1, 0); r.carries = 0; send_beat(r);
    x = rand_id(); y = rand_id();
    send_beat(good_record(x, 0));
    send_one(good_record(x, 0));
    send_one(good_record(x, y));
    send_beat(good_record(x, y));
    send_one(good_record(y, x));
    send_beat(good_record(y, 0));
    send_one(good_record(x, y));
    write_scene(8'(MaxNameBytesDef));
    end_set();
    write_scene(8'(MaxNameBytesDef + 1));
    send_one(good_record(x, 0));
    write_scene(8'hFF);
    end_set();

    phase = 0;
    while (records_sent < 400) begin
      case (phase % 4)
        0: begin gap_pct = 0;  stall_pct = 0;  end
        1: begin gap_pct = 47; stall_pct = 0;  end
        2: begin gap_pct = 0;  stall_pct = 47; end
        default: begin gap_pct = 12; stall_pct = 12; end
      endcase
      case ($urandom_range(7))
        0: write_scene(1);
        1: write_scene(8'(MaxNameBytesDef));
        2: write_scene(0);
        3: write_scene(8'($urandom_range(255, MaxNameBytesDef + 1)));
        default: write_scene(8'($urandom_range(MaxNameBytesDef, 1)));
      endcase
      for (int s = 0; s < 8; s++) random_set($urandom_range(10, 1));
      phase++;
    end

    gap_pct = 0;
    stall_pct = 0;
    write_scene(8'($urandom_range(MaxNameBytesDef, 1)));
    random_set(3);

    in_valid_i = 0;
    while (board.pending.size() != 0) @(negedge clk_i);
    repeat (100) @(negedge clk_i);
    $display("Sent %0d records in %0d sets, %0d verdicts checked, across four handshake mixes",
             records_sent, sets_sent, board.verdicts);
    $display("covering scene name, bad node, duplicate, missing parent, cycle and empty sets");
    if (board.errors == 0)
      $display("SCOREBOARD CLEAN");
    else
      $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
